FILE: rtl/core/ica_pkg.sv
// shared types and constants for the integer calculator alu
// no dependencies; imported by every module of the block
package ica_pkg;

  localparam int DW = 32;
  localparam int CMD_W = 3;
  localparam int ST_W = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD  = 3'd0,
    CMD_SUB  = 3'd1,
    CMD_MUL  = 3'd2,
    CMD_DIV  = 3'd3,
    CMD_POW  = 3'd4,
    CMD_SQRT = 3'd5,
    CMD_RECP = 3'd6,
    CMD_BAD  = 3'd7
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 3'd0,
    ST_DIV0    = 3'd1,
    ST_NEGROOT = 3'd2,
    ST_BADCMD  = 3'd3,
    ST_SAT     = 3'd4
  } status_t;

  localparam logic [DW-1:0] W_HALF = {1'b1, {(DW-1){1'b0}}};
  localparam logic [DW-1:0] W_MAXP = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] W_ONES = {DW{1'b1}};
  localparam logic [DW-1:0] W_ONE  = {{(DW-1){1'b0}}, 1'b1};

  // payload handed from cell to cell
  typedef struct packed {
    cmd_t            cmd;
    logic            early;
    logic [DW-1:0]   early_res;
    status_t         early_st;
    logic            q_neg;
    logic [DW:0]     div_rem;
    logic [DW-1:0]   div_den;
    logic [DW-1:0]   div_q;
    logic [2*DW-1:0] sq_rad;
    logic [DW+1:0]   sq_rem;
    logic [DW-1:0]   sq_root;
    logic [DW-1:0]   pw_p;
    logic [DW-1:0]   pw_m;
    logic [DW-1:0]   pw_e;
    logic            pw_sat;
    logic            pw_neg;
  } stage_t;

endpackage

FILE: rtl/core/ica_entry.sv
// entry stage: decodes the command, settles the simple operations and
// special cases, and loads the iteration state; depends on ica_pkg
module ica_entry (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [ica_pkg::CMD_W-1:0] cmd,
  input  logic [ica_pkg::DW-1:0]    operand_a,
  input  logic [ica_pkg::DW-1:0]    operand_b,
  output logic                      out_valid,
  output ica_pkg::stage_t           out_stage
);
  import ica_pkg::*;

  stage_t          stage_next;
  logic            a_neg;
  logic            b_neg;
  logic [DW-1:0]   mag_a;
  logic [DW-1:0]   mag_b;
  logic            rneg;
  logic [2*DW-1:0] mul_full;

  always_comb begin
    a_neg = operand_a[DW-1];
    b_neg = operand_b[DW-1];
    mag_a = a_neg ? (~operand_a + W_ONE) : operand_a;
    mag_b = b_neg ? (~operand_b + W_ONE) : operand_b;
    rneg = a_neg & mag_b[0];
    mul_full = {{DW{1'b0}}, operand_a} * {{DW{1'b0}}, operand_b};

    stage_next = '0;
    stage_next.cmd = cmd_t'(cmd);
    stage_next.early = 1'b1;
    stage_next.early_res = '0;
    stage_next.early_st = ST_OK;
    stage_next.q_neg = a_neg ^ b_neg;
    stage_next.div_den = mag_b;
    stage_next.div_q = mag_a;
    stage_next.sq_rad = {operand_a, {DW{1'b0}}};
    stage_next.pw_p = W_ONE;
    stage_next.pw_m = mag_a;
    stage_next.pw_e = mag_b;
    stage_next.pw_neg = rneg;

    unique case (cmd_t'(cmd))
      CMD_ADD: stage_next.early_res = operand_a + operand_b;
      CMD_SUB: stage_next.early_res = operand_a - operand_b;
      CMD_MUL: stage_next.early_res = mul_full[DW-1:0];
      CMD_DIV: begin
        if (operand_b == '0) stage_next.early_st = ST_DIV0;
        else stage_next.early = 1'b0;
      end
      CMD_POW: begin
        if (b_neg) begin
          if (mag_a == '0) stage_next.early_st = ST_DIV0;
          else if (mag_a == W_ONE) stage_next.early_res = rneg ? W_ONES : W_ONE;
        end else if (mag_b == '0) begin
          stage_next.early_res = W_ONE;
        end else if (mag_a == '0) begin
          stage_next.early_res = '0;
        end else if (mag_a == W_ONE) begin
          stage_next.early_res = rneg ? W_ONES : W_ONE;
        end else begin
          stage_next.early = 1'b0;
          // a base of two or more overflows at or before this many factors
          if (mag_b >= DW[DW-1:0]) begin
            stage_next.pw_sat = 1'b1;
            stage_next.pw_e = '0;
          end
        end
      end
      CMD_SQRT: begin
        if (a_neg) stage_next.early_st = ST_NEGROOT;
        else stage_next.early = 1'b0;
      end
      CMD_RECP: begin
        if (operand_a == '0) stage_next.early_st = ST_DIV0;
        else if (operand_a == W_ONE) stage_next.early_res = W_ONE;
        else if (operand_a == W_ONES) stage_next.early_res = W_ONES;
      end
      CMD_BAD: stage_next.early_st = ST_BADCMD;
      default: stage_next.early_st = ST_BADCMD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else out_valid <= start;
  end

  always_ff @(posedge clk) begin
    out_stage <= stage_next;
  end

endmodule

FILE: rtl/core/ica_cell.sv
// one cell of the chain: one quotient bit, one root bit and one power factor
// per cell, registered toward the next cell; depends on ica_pkg
module ica_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  ica_pkg::stage_t in_stage,
  output logic            out_valid,
  output ica_pkg::stage_t out_stage
);
  import ica_pkg::*;

  stage_t          stage_next;
  logic [DW:0]     rem_sh;
  logic [DW+1:0]   sq_sh;
  logic [DW+1:0]   sq_trial;
  logic [2*DW-1:0] prod;
  logic [2*DW-1:0] limit;

  always_comb begin
    stage_next = in_stage;

    // restoring division step
    rem_sh = {in_stage.div_rem[DW-1:0], in_stage.div_q[DW-1]};
    if (rem_sh >= {1'b0, in_stage.div_den}) begin
      stage_next.div_rem = rem_sh - {1'b0, in_stage.div_den};
      stage_next.div_q = {in_stage.div_q[DW-2:0], 1'b1};
    end else begin
      stage_next.div_rem = rem_sh;
      stage_next.div_q = {in_stage.div_q[DW-2:0], 1'b0};
    end

    // digit-by-digit root, two radicand bits per cell
    sq_sh = {in_stage.sq_rem[DW-1:0], in_stage.sq_rad[2*DW-1 -: 2]};
    sq_trial = {in_stage.sq_root, 2'b01};
    stage_next.sq_rad = {in_stage.sq_rad[2*DW-3:0], 2'b00};
    if (sq_sh >= sq_trial) begin
      stage_next.sq_rem = sq_sh - sq_trial;
      stage_next.sq_root = {in_stage.sq_root[DW-2:0], 1'b1};
    end else begin
      stage_next.sq_rem = sq_sh;
      stage_next.sq_root = {in_stage.sq_root[DW-2:0], 1'b0};
    end

    // one factor of the power while exponent remains
    prod = {{DW{1'b0}}, in_stage.pw_p} * {{DW{1'b0}}, in_stage.pw_m};
    limit = {{DW{1'b0}}, (in_stage.pw_neg ? W_HALF : W_MAXP)};
    if (in_stage.pw_e != '0 && !in_stage.pw_sat) begin
      stage_next.pw_e = in_stage.pw_e - W_ONE;
      if (prod > limit) stage_next.pw_sat = 1'b1;
      else stage_next.pw_p = prod[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else out_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    out_stage <= stage_next;
  end

endmodule

FILE: rtl/core/ica_final.sv
// output stage: picks the result for the command and applies signs
// depends on ica_pkg
module ica_final (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  ica_pkg::stage_t          in_stage,
  output logic                     done,
  output logic [ica_pkg::DW-1:0]   result,
  output logic [ica_pkg::ST_W-1:0] status
);
  import ica_pkg::*;

  logic [DW-1:0] res_next;
  status_t       st_next;

  always_comb begin
    res_next = in_stage.early_res;
    st_next = in_stage.early_st;
    if (!in_stage.early) begin
      st_next = ST_OK;
      unique case (in_stage.cmd)
        CMD_DIV: res_next = in_stage.q_neg ? (~in_stage.div_q + W_ONE) : in_stage.div_q;
        CMD_POW: begin
          if (in_stage.pw_sat) begin
            st_next = ST_SAT;
            res_next = in_stage.pw_neg ? W_HALF : W_MAXP;
          end else begin
            res_next = in_stage.pw_neg ? (~in_stage.pw_p + W_ONE) : in_stage.pw_p;
          end
        end
        // root of the radicand scaled by 2^DW carries DW/2 extra bits
        CMD_SQRT: res_next = {{(DW/2){1'b0}}, in_stage.sq_root[DW-1 -: DW/2]};
        default: res_next = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= in_valid;
  end

  always_ff @(posedge clk) begin
    result <= res_next;
    status <= st_next;
  end

endmodule

FILE: rtl/core/integer_calculator_alu_unit.sv
// Fully pipelined integer alu: a new operation is taken on every clock
// cycle (busy never rises), and its result appears with done once it
// has passed one entry stage, a chain of DW cells that each produce one
// quotient bit, one root bit and one power factor, and one output stage.
// Results leave in the order the operations came in, one per cycle, and
// the receiver cannot stall them.
// depends on ica_pkg, ica_entry, ica_cell, ica_final
module integer_calculator_alu_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [ica_pkg::CMD_W-1:0] cmd,
  input  logic [ica_pkg::DW-1:0]    operand_a,
  input  logic [ica_pkg::DW-1:0]    operand_b,
  output logic                      done,
  output logic [ica_pkg::DW-1:0]    result,
  output logic [ica_pkg::ST_W-1:0]  status
);
  import ica_pkg::*;

  logic   chain_valid [DW+1];
  stage_t chain_stage [DW+1];

  assign busy = 1'b0;

  ica_entry u_entry (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .out_valid (chain_valid[0]),
    .out_stage (chain_stage[0])
  );

  for (genvar i = 0; i < DW; i++) begin : g_cell
    ica_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (chain_valid[i]),
      .in_stage  (chain_stage[i]),
      .out_valid (chain_valid[i+1]),
      .out_stage (chain_stage[i+1])
    );
  end

  ica_final u_final (
    .clk      (clk),
    .rst      (rst),
    .in_valid (chain_valid[DW]),
    .in_stage (chain_stage[DW]),
    .done     (done),
    .result   (result),
    .status   (status)
  );

endmodule
